/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/gpdf_pkg.sv */
`timescale 1ns / 1ps

package gpdf_pkg;

  // Store sizing
  localparam int MaxPalettes = 128;
  localparam int AddrW       = (MaxPalettes > 1) ? $clog2(MaxPalettes) : 1;
  localparam int CountW      = $clog2(MaxPalettes + 1);

  // Field widths
  localparam int ColorW   = 24;
  localparam int ChanW    = 8;
  localparam int DistW    = 13;
  localparam int InDataW  = 4 * ColorW;
  localparam int OutDataW = 24;

  localparam logic [DistW-1:0] DistEmpty = 13'd8191;
  localparam logic [DistW-1:0] ThrReset  = 13'd75;

  // RGB to YCbCr coefficients, 16-bit fixed point
  localparam int YR      = 19595;
  localparam int YG      = 38470;
  localparam int YB      = 7471;
  localparam int YRound  = 32767;
  localparam int CbR     = 11059;
  localparam int CbG     = 21709;
  localparam int CbB     = 32767;
  localparam int CrR     = 32767;
  localparam int CrG     = 27439;
  localparam int CrB     = 5329;
  // rounding plus the 128 chroma offset, keeps the sums positive
  localparam int ChrBias = 32768 + 8388608;

  typedef struct packed {
    logic [ChanW-1:0] y;
    logic [ChanW-1:0] cb;
    logic [ChanW-1:0] cr;
  } ycc_t;

  typedef ycc_t [3:0] pal_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CONV   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_e;

endpackage

/* rtl/gpdf_ycc.sv */
`timescale 1ns / 1ps

// Shared color converter: one RGB color in, registered YCbCr out
module gpdf_ycc (
  input  logic                  clk_i,
  input  logic [23:0]           rgb_i,
  output gpdf_pkg::ycc_t        ycc_o
);
  import gpdf_pkg::*;

  logic [24:0] r, g, b;
  logic [24:0] y_sum, cb_sum, cr_sum;
  ycc_t        ycc_q;

  assign r = 25'(rgb_i[23:16]);
  assign g = 25'(rgb_i[15:8]);
  assign b = 25'(rgb_i[7:0]);

  // True sums stay in 0..2^24-1, so 25-bit wraparound is harmless
  always_comb begin
    y_sum  = r * 25'(YR) + g * 25'(YG) + b * 25'(YB) + 25'(YRound);
    cb_sum = b * 25'(CbB) + 25'(ChrBias) - r * 25'(CbR) - g * 25'(CbG);
    cr_sum = r * 25'(CrR) + 25'(ChrBias) - g * 25'(CrG) - b * 25'(CrB);
  end

  always_ff @(posedge clk_i) begin
    ycc_q.y  <= y_sum[23:16];
    ycc_q.cb <= cb_sum[23:16];
    ycc_q.cr <= cr_sum[23:16];
  end

  assign ycc_o = ycc_q;

endmodule

/* rtl/gpdf_dist.sv */
`timescale 1ns / 1ps

// Palette distance: 16 color distances, min per candidate color, sum of mins
module gpdf_dist (
  input  gpdf_pkg::pal_t                cand_i,
  input  gpdf_pkg::pal_t                stored_i,
  output logic [gpdf_pkg::DistW-1:0]    sum_o
);
  import gpdf_pkg::*;

  localparam int CDistW = 11;  // 4*255 + 255 + 255 = 1530

  function automatic logic [ChanW-1:0] abs_diff(logic [ChanW-1:0] a, logic [ChanW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [CDistW-1:0] color_dist(ycc_t a, ycc_t b);
    color_dist = {1'b0, abs_diff(a.y, b.y), 2'b00}
               + CDistW'(abs_diff(a.cb, b.cb))
               + CDistW'(abs_diff(a.cr, b.cr));
  endfunction

  logic [CDistW-1:0] d    [4][4];
  logic [CDistW-1:0] mn   [4];

  // Distance grid and per-candidate minimum
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        d[i][j] = color_dist(cand_i[i], stored_i[j]);
      end
      mn[i] = d[i][0];
      for (int j = 1; j < 4; j++) begin
        if (d[i][j] < mn[i]) begin
          mn[i] = d[i][j];
        end
      end
    end
  end

  assign sum_o = DistW'(mn[0]) + DistW'(mn[1]) + DistW'(mn[2]) + DistW'(mn[3]);

endmodule

/* rtl/greedy_palette_diversity_filter_unit.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Greedy palette filter. Each input transfer carries a candidate palette of four
// RGB colors; one result transfer follows with accepted, min_distance, store_full
// and stored_count. The four colors go through one shared YCbCr converter, then
// the stored palettes are read back one memory row per cycle and scored by a
// single 16-way distance unit. The block takes no new input until the result of
// the current item is in the output register; a finished result sits there and
// the next input is taken while it waits. Palettes are kept in YCbCr form, so
// stored colors are never reconverted. The threshold register resets to 75; the
// user must write it through the cfg channel only while the block is idle, as
// the block does not enforce this.
module greedy_palette_diversity_filter_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // color0, color1, color2, color3 from bit 0 up, 24 bits each
  input  logic [gpdf_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // accepted[0], min_distance[13:1], store_full[14], stored_count[22:15], zero pad
  output logic [gpdf_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  input  logic [gpdf_pkg::DistW-1:0]     cfg_data_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o
);
  import gpdf_pkg::*;

  state_e              state_q, state_d;
  logic [ColorW-1:0]   rgb_q [4];
  logic [2:0]          cnt_q;
  pal_t                cand_q;
  logic [CountW-1:0]   count_q;
  logic [CountW-1:0]   count_nxt;
  logic [CountW-1:0]   issue_q;
  logic                rd_vld_q, sum_vld_q;
  pal_t                rd_data_q;
  logic [DistW-1:0]    sum_q, sum_d;
  logic [DistW-1:0]    best_q;
  logic [DistW-1:0]    thr_q;
  ycc_t                ycc_out;
  pal_t                mem [MaxPalettes];

  logic                in_xfer, dec_fire, qualify, has_room, dec_accept;
  logic                mem_re, scan_done;

  logic                out_vld_q, acc_q, full_q;
  logic [DistW-1:0]    dist_q;
  logic [7:0]          cnt8_q;

  assign in_xfer    = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign mem_re     = (state_q == S_SCAN) && (issue_q < count_q);
  assign scan_done  = (state_q == S_SCAN) && (issue_q == count_q) && !rd_vld_q && !sum_vld_q;
  assign dec_fire   = (state_q == S_DECIDE) && (!out_vld_q || m_axis_tready_i);
  assign qualify    = best_q > thr_q;
  assign has_room   = count_q < CountW'(MaxPalettes);
  assign dec_accept = qualify && has_room;
  assign count_nxt  = count_q + CountW'(1);

  // Shared converter and distance unit
  gpdf_ycc u_ycc (
    .clk_i (clk_i),
    .rgb_i (rgb_q[cnt_q[1:0]]),
    .ycc_o (ycc_out)
  );

  gpdf_dist u_dist (
    .cand_i   (cand_q),
    .stored_i (rd_data_q),
    .sum_o    (sum_d)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_xfer) state_d = S_CONV;
      S_CONV:   if (cnt_q == 3'd4) state_d = S_SCAN;
      S_SCAN:   if (scan_done) state_d = S_DECIDE;
      S_DECIDE: if (dec_fire) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      issue_q   <= '0;
      rd_vld_q  <= 1'b0;
      sum_vld_q <= 1'b0;
      count_q   <= '0;
      thr_q     <= ThrReset;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= mem_re;
      sum_vld_q <= rd_vld_q;
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_data_i;
      end
      if (in_xfer) begin
        cnt_q   <= '0;
        issue_q <= '0;
      end else if (state_q == S_CONV) begin
        cnt_q <= cnt_q + 3'd1;
      end
      if (mem_re) begin
        issue_q <= issue_q + CountW'(1);
      end
      if (dec_fire && dec_accept) begin
        count_q <= count_nxt;
      end
      // output register valid
      if (dec_fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload: input latch, converted candidate, running minimum, result fields
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int k = 0; k < 4; k++) begin
        rgb_q[k] <= s_axis_tdata_i[k*ColorW +: ColorW];
      end
      best_q <= DistEmpty;
    end
    if ((state_q == S_CONV) && (cnt_q != 3'd0)) begin
      cand_q[2'(cnt_q - 3'd1)] <= ycc_out;
    end
    if (rd_vld_q) begin
      sum_q <= sum_d;
    end
    if (sum_vld_q && (sum_q < best_q)) begin
      best_q <= sum_q;
    end
    if (dec_fire) begin
      acc_q  <= dec_accept;
      full_q <= qualify && !has_room;
      dist_q <= best_q;
      cnt8_q <= dec_accept ? 8'(count_nxt) : 8'(count_q);
    end
  end

  // Palette store, one palette per row
  always_ff @(posedge clk_i) begin
    if (dec_fire && dec_accept) begin
      mem[count_q[AddrW-1:0]] <= cand_q;
    end
    if (mem_re) begin
      rd_data_q <= mem[issue_q[AddrW-1:0]];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, cnt8_q, full_q, dist_q, acc_q};

  // Checks
  `ASSERT_ALWAYS(a_count_bound, count_q <= CountW'(MaxPalettes), "palette count exceeds store")
  `ASSERT_CLK(a_count_step, dec_fire && dec_accept |=> count_q == $past(count_nxt), "count stuck")
  `ASSERT_CLK(a_empty_dist, dec_fire && count_q == '0 |-> best_q == DistEmpty, "empty store dist")
  `ASSERT_CLK(a_acc_full_excl, m_axis_tvalid_o |-> !(acc_q && full_q), "accepted with store_full")

endmodule
